[rtl/sdc_pkg.sv]
// Package for the solar calendar date counter: op codes, calendar constants,
// leap-year and month-length functions. No dependencies.
package sdc_pkg;

    localparam int OP_W          = 2;
    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_MAX_BITS = 20;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 2'd0,
        OP_LOAD    = 2'd1,
        OP_COMPARE = 2'd2
    } t_op;

    localparam logic [DAY_W-1:0]   DAYS_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_LAST   = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] LONG_LAST   = 4'd6;
    localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;

    // year mod 33 by reciprocal multiply, exact over YEAR_MAX_BITS
    localparam int CYCLE       = 33;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = YEAR_MAX_BITS + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] CYCLE_RECIP = RECIP_W'(((2 ** RECIP_SHIFT) + CYCLE - 1) / CYCLE);
    localparam logic [YEAR_MAX_BITS:0] CYCLE_W = (YEAR_MAX_BITS + 1)'(CYCLE);

    function automatic logic leap_of(input logic [YEAR_MAX_BITS-1:0] year);
        logic [PROD_W-1:0]        prod;
        logic [QUOT_W-1:0]        quot;
        logic [YEAR_MAX_BITS:0]   prod33;
        logic [YEAR_MAX_BITS:0]   rem;
        logic [5:0]               res;
        logic                     leap;
        prod   = PROD_W'(year) * PROD_W'(CYCLE_RECIP);
        quot   = prod[PROD_W-1:RECIP_SHIFT];
        prod33 = (YEAR_MAX_BITS + 1)'({quot, 5'b0}) + (YEAR_MAX_BITS + 1)'(quot);
        rem    = {1'b0, year} - prod33;
        if (rem >= CYCLE_W) begin
            rem = rem - CYCLE_W;
        end
        res = rem[5:0];
        case (res)
            6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: leap = 1'b1;
            default: leap = 1'b0;
        endcase
        return leap;
    endfunction

    // zero for a month number outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (month >= MONTH_FIRST && month <= LONG_LAST) begin
            len = DAYS_LONG;
        end else if (month > LONG_LAST && month < MONTHS) begin
            len = DAYS_SHORT;
        end else if (month == MONTHS) begin
            len = leap ? DAYS_SHORT : DAYS_LAST;
        end else begin
            len = '0;
        end
        return len;
    endfunction

endpackage

[rtl/sdc_in_stage.sv]
// Input register stage of the date counter.
// Depends on sdc_pkg.
module sdc_in_stage #(
    parameter int YEAR_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  sdc_pkg::t_op                 i_op,
    input  logic [sdc_pkg::DAY_W-1:0]    i_day,
    input  logic [sdc_pkg::MONTH_W-1:0]  i_month,
    input  logic [YEAR_BITS-1:0]         i_year,
    output logic                         o_valid,
    input  logic                         i_take,
    output sdc_pkg::t_op                 o_op,
    output logic [sdc_pkg::DAY_W-1:0]    o_day,
    output logic [sdc_pkg::MONTH_W-1:0]  o_month,
    output logic [YEAR_BITS-1:0]         o_year
);
    import sdc_pkg::*;

    logic                r_valid;
    t_op                 r_op;
    logic [DAY_W-1:0]    r_day;
    logic [MONTH_W-1:0]  r_month;
    logic [YEAR_BITS-1:0] r_year;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_op;
            r_day   <= i_day;
            r_month <= i_month;
            r_year  <= i_year;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_day   = r_day;
    assign o_month = r_month;
    assign o_year  = r_year;

endmodule

[rtl/sdc_date_unit.sv]
// Date state, advance/load/compare logic and result register.
// Depends on sdc_pkg.
module sdc_date_unit #(
    parameter int YEAR_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_take,
    input  sdc_pkg::t_op                 i_op,
    input  logic [sdc_pkg::DAY_W-1:0]    i_day,
    input  logic [sdc_pkg::MONTH_W-1:0]  i_month,
    input  logic [YEAR_BITS-1:0]         i_year,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sdc_pkg::DAY_W-1:0]    o_day,
    output logic [sdc_pkg::MONTH_W-1:0]  o_month,
    output logic [YEAR_BITS-1:0]         o_year,
    output logic                         o_rejected,
    output logic                         o_given_later,
    output logic                         o_given_equal,
    output logic                         o_leap_year
);
    import sdc_pkg::*;

    logic [DAY_W-1:0]     r_day, n_day;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [YEAR_BITS-1:0] r_year, n_year;
    logic                 r_leap, n_leap;

    logic                 r_out_valid;
    logic [DAY_W-1:0]     r_out_day;
    logic [MONTH_W-1:0]   r_out_month;
    logic [YEAR_BITS-1:0] r_out_year;
    logic                 r_out_rejected, n_rejected;
    logic                 r_out_later, n_later;
    logic                 r_out_equal, n_equal;
    logic                 r_out_leap;

    logic [YEAR_BITS-1:0] year_inc;
    logic                 leap_inc;
    logic                 leap_given;
    logic [DAY_W-1:0]     cur_len;
    logic [DAY_W-1:0]     given_len;
    logic                 load_ok;
    logic                 fire;

    assign o_take = !r_out_valid || i_ready;
    assign fire   = i_valid && o_take;

    assign year_inc   = r_year + YEAR_BITS'(1);
    assign leap_inc   = leap_of(YEAR_MAX_BITS'(year_inc));
    assign leap_given = leap_of(YEAR_MAX_BITS'(i_year));
    assign cur_len    = month_len(r_month, r_leap);
    assign given_len  = month_len(i_month, leap_given);
    assign load_ok    = (given_len != '0) && (i_day != '0) && (i_day <= given_len);

    always_comb begin
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_leap     = r_leap;
        n_rejected = 1'b0;
        n_later    = 1'b0;
        n_equal    = 1'b0;
        case (i_op)
            OP_ADVANCE: begin
                if (r_day >= cur_len) begin
                    n_day = DAY_FIRST;
                    if (r_month >= MONTHS) begin
                        n_month = MONTH_FIRST;
                        n_year  = year_inc;
                        n_leap  = leap_inc;
                    end else begin
                        n_month = r_month + MONTH_W'(1);
                    end
                end else begin
                    n_day = r_day + DAY_W'(1);
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    n_day   = i_day;
                    n_month = i_month;
                    n_year  = i_year;
                    n_leap  = leap_given;
                end else begin
                    n_rejected = 1'b1;
                end
            end
            OP_COMPARE: begin
                n_later = (i_year > r_year) ||
                          ((i_year == r_year) && ((i_month > r_month) ||
                           ((i_month == r_month) && (i_day > r_day))));
                n_equal = (i_year == r_year) && (i_month == r_month) && (i_day == r_day);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= DAY_FIRST;
            r_month     <= MONTH_FIRST;
            r_year      <= '0;
            r_leap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_leap  <= n_leap;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_day      <= n_day;
            r_out_month    <= n_month;
            r_out_year     <= n_year;
            r_out_rejected <= n_rejected;
            r_out_later    <= n_later;
            r_out_equal    <= n_equal;
            r_out_leap     <= n_leap;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_day         = r_out_day;
    assign o_month       = r_out_month;
    assign o_year        = r_out_year;
    assign o_rejected    = r_out_rejected;
    assign o_given_later = r_out_later;
    assign o_given_equal = r_out_equal;
    assign o_leap_year   = r_out_leap;

endmodule

[rtl/solar_calendar_date_counter_core.sv]
// Solar calendar date counter: advance, load or compare one date per word.
// Pipeline: input register, then result register, from input accept to result valid.
// Throughput: one word per cycle when m_axis_tready is high, set by the date update loop.
// Reset (synchronous, active low): date 1/1/0, both pipeline registers empty.
// Depends on sdc_pkg, sdc_in_stage, sdc_date_unit.
module solar_calendar_date_counter_core #(
    parameter int YEAR_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // in_day, in_month, in_year, zero pad
    input  logic [(((sdc_pkg::DAY_W + sdc_pkg::MONTH_W + YEAR_BITS) + 7) / 8) * 8 - 1:0]
                                s_axis_tdata,
    // op
    input  logic [sdc_pkg::OP_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_day, out_month, out_year, rejected, given_later, given_equal, leap_year, zero pad
    output logic [(((sdc_pkg::DAY_W + sdc_pkg::MONTH_W + YEAR_BITS + 4) + 7) / 8) * 8 - 1:0]
                                m_axis_tdata
);
    import sdc_pkg::*;

    localparam int OUT_W     = DAY_W + MONTH_W + YEAR_BITS + 4;
    localparam int OUT_TDATA = ((OUT_W + 7) / 8) * 8;

    logic                 st_valid;
    logic                 st_take;
    t_op                  st_op;
    logic [DAY_W-1:0]     st_day;
    logic [MONTH_W-1:0]   st_month;
    logic [YEAR_BITS-1:0] st_year;

    logic [DAY_W-1:0]     out_day;
    logic [MONTH_W-1:0]   out_month;
    logic [YEAR_BITS-1:0] out_year;
    logic                 out_rejected;
    logic                 out_later;
    logic                 out_equal;
    logic                 out_leap;

    sdc_in_stage #(
        .YEAR_BITS (YEAR_BITS)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (t_op'(s_axis_tuser)),
        .i_day   (s_axis_tdata[DAY_W-1:0]),
        .i_month (s_axis_tdata[DAY_W +: MONTH_W]),
        .i_year  (s_axis_tdata[DAY_W + MONTH_W +: YEAR_BITS]),
        .o_valid (st_valid),
        .i_take  (st_take),
        .o_op    (st_op),
        .o_day   (st_day),
        .o_month (st_month),
        .o_year  (st_year)
    );

    sdc_date_unit #(
        .YEAR_BITS (YEAR_BITS)
    ) u_date_unit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (st_valid),
        .o_take        (st_take),
        .i_op          (st_op),
        .i_day         (st_day),
        .i_month       (st_month),
        .i_year        (st_year),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_day         (out_day),
        .o_month       (out_month),
        .o_year        (out_year),
        .o_rejected    (out_rejected),
        .o_given_later (out_later),
        .o_given_equal (out_equal),
        .o_leap_year   (out_leap)
    );

    assign m_axis_tdata = OUT_TDATA'({out_leap, out_equal, out_later, out_rejected,
                                      out_year, out_month, out_day});

endmodule
